[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/lfu_pkg.sv]
package lfu_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 5;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

endpackage

[rtl/lfu_cache_table.sv]
// Key-value cache with least-frequently-used replacement and least-recently-used tie break.
// One access (get or put) is taken at a time. The table is held in small memories that are
// read one entry per cycle. A first pass over all ENTRIES slots finds the key, the victim
// (lowest use count, oldest among equals) and the first free slot. After a decision cycle, a
// second pass over all slots rewrites the recency ranks after a get hit, a put hit or an
// insert. A get miss, or a put while capacity is zero, skips the second pass. Both passes
// run through the single read port of each table memory, which sets the rate. The result
// stays in an output register until taken, and the next word is accepted only once the
// block is back in its idle state, in the cycle after the result is loaded.
// Capacity is written at byte address 0 and is clamped to ENTRIES; writing it lower than
// the entries in use makes each new-key put evict one entry.
`include "assert_macros.svh"

module lfu_cache_table #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_action,
    input  logic signed [lfu_pkg::KEY_W-1:0] i_key,
    input  logic signed [lfu_pkg::VAL_W-1:0] i_value,

    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit,
    output logic signed [lfu_pkg::VAL_W-1:0] o_read_value,
    output logic                            o_evicted,
    output logic signed [lfu_pkg::KEY_W-1:0] o_evicted_key,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfu_pkg::ADDR_W-1:0]      paddr,
    input  logic [lfu_pkg::DATA_W-1:0]      pwdata,
    output logic [lfu_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lfu_pkg::CAP_W) ? CW : lfu_pkg::CAP_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES);

    // Table memories.
    logic [lfu_pkg::KEY_W-1:0] r_key_mem   [ENTRIES];
    logic [lfu_pkg::VAL_W-1:0] r_value_mem [ENTRIES];
    logic [COUNT_BITS-1:0]     r_count_mem [ENTRIES];
    logic [IW-1:0]             r_rank_mem  [ENTRIES];

    logic [lfu_pkg::KEY_W-1:0] r_key_rd;
    logic [lfu_pkg::VAL_W-1:0] r_value_rd;
    logic [COUNT_BITS-1:0]     r_count_rd;
    logic [IW-1:0]             r_rank_rd;

    logic [ENTRIES-1:0]        r_valid;
    logic [ENTRIES-1:0]        n_valid;
    logic [CW-1:0]             r_used;
    logic [lfu_pkg::CAP_W-1:0] r_capacity;

    lfu_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_didx;

    // Latched request.
    logic                      r_act;
    logic [lfu_pkg::KEY_W-1:0] r_key;
    logic [lfu_pkg::VAL_W-1:0] r_in_value;

    // Scan results.
    logic                      r_found;
    logic [IW-1:0]             r_s_slot;
    logic [IW-1:0]             r_s_rank;
    logic [COUNT_BITS-1:0]     r_s_count;
    logic [lfu_pkg::VAL_W-1:0] r_s_value;
    logic                      r_vic_found;
    logic [IW-1:0]             r_vic;
    logic [IW-1:0]             r_vic_rank;
    logic [COUNT_BITS-1:0]     r_vic_count;
    logic [lfu_pkg::KEY_W-1:0] r_vic_key;
    logic                      r_free_found;
    logic [IW-1:0]             r_free;

    // Decision.
    logic          r_touch;
    logic          r_ins;
    logic          r_evict;
    logic [IW-1:0] r_tgt;

    // Output register.
    logic                      r_out_valid;
    logic                      r_out_hit;
    logic [lfu_pkg::VAL_W-1:0] r_out_value;
    logic                      r_out_evicted;
    logic [lfu_pkg::KEY_W-1:0] r_out_evk;

    logic                  accept;
    logic                  cfg_wr;
    logic                  pass_active;
    logic                  pass_last;
    logic                  cur_valid;
    logic                  key_match;
    logic                  vic_better;
    logic                  is_get;
    logic                  cap_zero;
    logic [CMPW-1:0]       cap_x;
    logic [CMPW-1:0]       cap_eff;
    logic                  d_bump;
    logic                  d_put_miss;
    logic                  d_evict;
    logic                  d_ins;
    logic [IW-1:0]         d_ins_slot;
    logic [IW-1:0]         d_tgt;
    logic [COUNT_BITS-1:0] bumped_count;
    logic                  wr_count;
    logic                  wr_key;
    logic                  wr_value;
    logic [COUNT_BITS-1:0] wr_count_data;
    logic [IW-1:0]         new_rank;
    logic                  out_load;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == lfu_pkg::ST_IDLE);
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == lfu_pkg::REG_CAPACITY) ?
                         lfu_pkg::DATA_W'(r_capacity) : '0;

    assign pass_active = (r_state == lfu_pkg::ST_SCAN) || (r_state == lfu_pkg::ST_UPDATE);
    assign pass_last   = (r_idx == LAST_IDX);
    assign out_load    = (r_state == lfu_pkg::ST_DONE) && (!r_out_valid || i_ready);

    // Per-entry compare on the word that came back from the memories.
    assign cur_valid  = r_valid[r_didx];
    assign key_match  = cur_valid && (r_key_rd == r_key);
    assign vic_better = cur_valid && (!r_vic_found || (r_count_rd < r_vic_count) ||
                        ((r_count_rd == r_vic_count) && (r_rank_rd > r_vic_rank)));

    // Decision made once the scan is complete.
    assign is_get       = (r_act == lfu_pkg::ACT_GET);
    assign cap_zero     = (r_capacity == '0);
    assign cap_x        = CMPW'(r_capacity);
    assign cap_eff      = (cap_x > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_x;
    assign d_bump       = r_found && (is_get || !cap_zero);
    assign d_put_miss   = !is_get && !r_found && !cap_zero;
    assign d_evict      = d_put_miss && (CMPW'(r_used) >= cap_eff) && r_vic_found;
    assign d_ins        = d_put_miss && (d_evict || r_free_found);
    assign d_ins_slot   = (d_evict && (!r_free_found || (r_vic < r_free))) ? r_vic : r_free;
    assign d_tgt        = d_bump ? r_s_slot : d_ins_slot;
    assign bumped_count = (r_s_count == COUNT_MAX) ? r_s_count : r_s_count + 1'b1;

    assign wr_count      = (r_state == lfu_pkg::ST_DECIDE) && (d_bump || d_ins);
    assign wr_key        = (r_state == lfu_pkg::ST_DECIDE) && d_ins;
    assign wr_value      = (r_state == lfu_pkg::ST_DECIDE) && (d_ins || (d_bump && !is_get));
    assign wr_count_data = d_bump ? bumped_count : COUNT_BITS'(1);

    // Recency rewrite. A touch ages the entries newer than the touched one. An insert ages
    // every surviving entry, except those above the victim, whose step down cancels it.
    always_comb begin
        new_rank = r_rank_rd;
        if (r_didx == r_tgt) begin
            new_rank = '0;
        end else if (r_touch) begin
            if (cur_valid && (r_rank_rd < r_s_rank)) begin
                new_rank = r_rank_rd + 1'b1;
            end
        end else if (cur_valid && !(r_evict && (r_didx == r_vic))) begin
            if (!(r_evict && (r_rank_rd > r_vic_rank))) begin
                new_rank = r_rank_rd + 1'b1;
            end
        end
    end

    // The victim slot is freed and the target slot filled; they may be the same slot.
    always_comb begin
        n_valid = r_valid;
        if (r_evict) begin
            n_valid[r_vic] = 1'b0;
        end
        n_valid[r_tgt] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            r_key_mem[d_tgt] <= r_key;
        end
        r_key_rd <= r_key_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_value) begin
            r_value_mem[d_tgt] <= r_in_value;
        end
        r_value_rd <= r_value_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_count) begin
            r_count_mem[d_tgt] <= wr_count_data;
        end
        r_count_rd <= r_count_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lfu_pkg::ST_UPDATE) && r_rd_vld) begin
            r_rank_mem[r_didx] <= new_rank;
        end
        r_rank_rd <= r_rank_mem[r_idx[IW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (pass_last) begin
                    n_state = lfu_pkg::ST_DECIDE;
                end
            end
            lfu_pkg::ST_DECIDE: begin
                n_state = (d_bump || d_ins) ? lfu_pkg::ST_UPDATE : lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_UPDATE: begin
                if (pass_last) begin
                    n_state = lfu_pkg::ST_DONE;
                end
            end
            lfu_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = lfu_pkg::ST_IDLE;
                end
            end
            default: n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lfu_pkg::ST_IDLE;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_valid    <= '0;
            r_used     <= '0;
            r_capacity <= lfu_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= pass_active && !pass_last;
            if (pass_active && !pass_last) begin
                r_idx <= r_idx + 1'b1;
            end else begin
                r_idx <= '0;
            end
            if (cfg_wr && (paddr[2] == lfu_pkg::REG_CAPACITY)) begin
                r_capacity <= pwdata[lfu_pkg::CAP_W-1:0];
            end
            // Occupancy changes once the rank pass of an insert is finished.
            if ((r_state == lfu_pkg::ST_UPDATE) && pass_last && r_ins) begin
                if (!r_evict) begin
                    r_used <= r_used + 1'b1;
                end
                r_valid <= n_valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= r_idx[IW-1:0];
        if (accept) begin
            r_act        <= i_action;
            r_key        <= i_key;
            r_in_value   <= i_value;
            r_found      <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_s_slot     <= '0;
            r_s_rank     <= '0;
            r_s_count    <= '0;
            r_s_value    <= '0;
        end
        if ((r_state == lfu_pkg::ST_SCAN) && r_rd_vld) begin
            if (key_match) begin
                r_found   <= 1'b1;
                r_s_slot  <= r_didx;
                r_s_rank  <= r_rank_rd;
                r_s_count <= r_count_rd;
                r_s_value <= r_value_rd;
            end
            if (vic_better) begin
                r_vic_found <= 1'b1;
                r_vic       <= r_didx;
                r_vic_rank  <= r_rank_rd;
                r_vic_count <= r_count_rd;
                r_vic_key   <= r_key_rd;
            end
            if (!cur_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free       <= r_didx;
            end
        end
        if (r_state == lfu_pkg::ST_DECIDE) begin
            r_touch <= d_bump;
            r_ins   <= d_ins;
            r_evict <= d_evict;
            r_tgt   <= d_tgt;
        end
        if (out_load) begin
            r_out_hit     <= r_found;
            r_out_evicted <= r_evict && r_ins && !r_touch;
            r_out_evk     <= (r_evict && r_ins && !r_touch) ? r_vic_key : '0;
            if (!is_get) begin
                r_out_value <= '0;
            end else if (r_found) begin
                r_out_value <= r_s_value;
            end else begin
                r_out_value <= '1;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_value;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evk;

    `ASSERT_CHK(a_used_matches_valid, i_clk, i_rst_n, ($countones(r_valid) == r_used), "entry count does not match valid bits")
    `ASSERT_CHK(a_used_bounded, i_clk, i_rst_n, (r_used <= LAST_IDX), "entries in use exceed table size")
    `ASSERT_CHK(a_evict_implies_insert, i_clk, i_rst_n, (!((r_state == lfu_pkg::ST_UPDATE) && r_evict && !r_touch) || r_ins), "eviction without insert")
    `ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, accept, (r_state == lfu_pkg::ST_SCAN), "accepted word did not start a scan")

endmodule
